// File: rtl/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg
// Shared codes and field widths for the array doubly linked list unit.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEAD_INS  = 3'd0,
    KIND_TAIL_INS  = 3'd1,
    KIND_LEFT_INS  = 3'd2,
    KIND_RIGHT_INS = 3'd3,
    KIND_DELETE    = 3'd4,
    KIND_WALK_START = 3'd5,
    KIND_WALK_NEXT = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_END        = 2'd3
  } status_t;

endpackage

// File: rtl/adll_ram.sv
// ----------------------------------------------------------------------------
// adll_ram
// Simple dual-port memory: one write port with a bit write mask, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module adll_ram #(
  parameter int DEPTH = 1026,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/adll_ctrl.sv
// ----------------------------------------------------------------------------
// adll_ctrl
// Request sequencer: checks handles, walks the cursor and drives the
// read-modify-write traffic to the left-link and node memories.
// ----------------------------------------------------------------------------
module adll_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [adll_pkg::KIND_W-1:0]          kind,
  input  logic [$clog2(CAPACITY+1)-1:0]        node_handle,
  input  logic signed [adll_pkg::DATA_W-1:0]   new_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [adll_pkg::STATUS_W-1:0]        status,
  output logic [$clog2(CAPACITY+1)-1:0]        assigned_handle,
  output logic signed [adll_pkg::DATA_W-1:0]   read_value,
  output logic                                 is_last,
  output logic                                 p_we,
  output logic [$clog2(CAPACITY+2)-1:0]        p_waddr,
  output logic [$clog2(CAPACITY+2)-1:0]        p_wdata,
  output logic [$clog2(CAPACITY+2)-1:0]        p_raddr,
  input  logic [$clog2(CAPACITY+2)-1:0]        p_rdata,
  output logic                                 n_we,
  output logic [$clog2(CAPACITY+2)+adll_pkg::DATA_W:0] n_wmask,
  output logic [$clog2(CAPACITY+2)-1:0]        n_waddr,
  output logic [$clog2(CAPACITY+2)+adll_pkg::DATA_W:0] n_wdata,
  output logic [$clog2(CAPACITY+2)-1:0]        n_raddr,
  input  logic [$clog2(CAPACITY+2)+adll_pkg::DATA_W:0] n_rdata
);

  localparam int SLOTS = CAPACITY + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int HW    = $clog2(CAPACITY + 1);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int CW    = HW + 1;
  localparam int DW    = adll_pkg::DATA_W;
  localparam int NW    = SW + DW + 1;

  localparam logic [SW-1:0] HEAD_SLOT = '0;
  localparam logic [SW-1:0] TAIL_SLOT = SW'(1);
  localparam logic [FW-1:0] FULL_MARK = FW'(SLOTS);

  localparam logic [NW-1:0] MASK_ALL   = '1;
  localparam logic [NW-1:0] MASK_RIGHT = {1'b0, {SW{1'b1}}, {DW{1'b0}}};
  localparam logic [NW-1:0] MASK_LIVE  = {1'b1, {(NW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_W1,
    S_W2,
    S_D1,
    S_D2,
    S_STEP,
    S_WREAD,
    S_DONE
  } state_t;

  state_t                  state;
  logic [adll_pkg::KIND_W-1:0] kind_q;
  logic [SW-1:0]           slot_q;
  logic [DW-1:0]           value_q;
  logic [SW-1:0]           after_q;
  logic [SW-1:0]           nxt_q;
  logic [SW-1:0]           cursor;
  logic [SW-1:0]           head_right;
  logic [SW-1:0]           tail_left;
  logic [FW-1:0]           next_free;
  logic [adll_pkg::STATUS_W-1:0] res_status;
  logic [HW-1:0]           res_handle;
  logic [DW-1:0]           res_value;
  logic                    res_last;

  logic                    accept;
  logic                    full;
  logic [SW-1:0]           new_slot;
  logic [SW-1:0]           hslot;
  logic [CW-1:0]           hsum;
  logic                    handle_pre_ok;
  logic                    n_live;
  logic [SW-1:0]           n_right;
  logic [DW-1:0]           n_value;
  logic [SW-1:0]           rd_addr;

  assign in_stall      = (state != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign full          = (next_free == FULL_MARK);
  assign new_slot      = next_free[SW-1:0];
  assign hslot         = SW'(node_handle) + SW'(1);
  assign hsum          = CW'(node_handle) + CW'(1);
  assign handle_pre_ok = (node_handle != '0) && (hsum < CW'(next_free));
  assign n_live        = n_rdata[NW-1];
  assign n_right       = n_rdata[NW-2 -: SW];
  assign n_value       = n_rdata[DW-1:0];
  assign p_raddr       = rd_addr;
  assign n_raddr       = rd_addr;

  always_comb begin
    rd_addr = cursor;
    unique case (state)
      S_IDLE: begin
        if (kind == adll_pkg::KIND_WALK_START) begin
          rd_addr = head_right;
        end else if (kind == adll_pkg::KIND_WALK_NEXT) begin
          rd_addr = (cursor == HEAD_SLOT) ? head_right : cursor;
        end else begin
          rd_addr = hslot;
        end
      end
      S_STEP:  rd_addr = n_right;
      default: rd_addr = cursor;
    endcase
  end

  always_comb begin
    p_we    = 1'b0;
    p_waddr = nxt_q;
    p_wdata = new_slot;
    n_we    = 1'b0;
    n_wmask = MASK_RIGHT;
    n_waddr = after_q;
    n_wdata = {1'b0, new_slot, {DW{1'b0}}};
    unique case (state)
      S_W1: begin
        p_we    = 1'b1;
        p_waddr = new_slot;
        p_wdata = after_q;
        n_we    = 1'b1;
        n_wmask = MASK_ALL;
        n_waddr = new_slot;
        n_wdata = {1'b1, nxt_q, value_q};
      end
      S_W2: begin
        p_we = (nxt_q != TAIL_SLOT);
        n_we = (after_q != HEAD_SLOT);
      end
      S_D1: begin
        p_we    = (nxt_q != TAIL_SLOT);
        p_wdata = after_q;
        n_we    = (after_q != HEAD_SLOT);
        n_wdata = {1'b0, nxt_q, {DW{1'b0}}};
      end
      S_D2: begin
        n_we    = 1'b1;
        n_wmask = MASK_LIVE;
        n_waddr = slot_q;
        n_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= TAIL_SLOT;
      head_right <= TAIL_SLOT;
      tail_left  <= HEAD_SLOT;
      next_free  <= FW'(2);
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q     <= kind;
            slot_q     <= hslot;
            value_q    <= new_value;
            res_handle <= '0;
            res_value  <= '0;
            res_last   <= 1'b0;
            unique case (kind)
              adll_pkg::KIND_HEAD_INS, adll_pkg::KIND_TAIL_INS: begin
                after_q <= (kind == adll_pkg::KIND_HEAD_INS) ? HEAD_SLOT : tail_left;
                nxt_q   <= (kind == adll_pkg::KIND_HEAD_INS) ? head_right : TAIL_SLOT;
                if (full) begin
                  res_status <= adll_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= adll_pkg::ST_OK;
                  state      <= S_W1;
                end
              end
              adll_pkg::KIND_LEFT_INS, adll_pkg::KIND_RIGHT_INS,
              adll_pkg::KIND_DELETE: begin
                if (handle_pre_ok) begin
                  res_status <= adll_pkg::ST_OK;
                  state      <= S_CHECK;
                end else begin
                  res_status <= adll_pkg::ST_BAD_HANDLE;
                  state      <= S_DONE;
                end
              end
              adll_pkg::KIND_WALK_START: begin
                if (head_right == TAIL_SLOT) begin
                  cursor     <= TAIL_SLOT;
                  res_status <= adll_pkg::ST_END;
                  state      <= S_DONE;
                end else begin
                  cursor     <= head_right;
                  res_status <= adll_pkg::ST_OK;
                  state      <= S_WREAD;
                end
              end
              adll_pkg::KIND_WALK_NEXT: begin
                if (cursor == TAIL_SLOT) begin
                  res_status <= adll_pkg::ST_END;
                  state      <= S_DONE;
                end else if (cursor == HEAD_SLOT) begin
                  if (head_right == TAIL_SLOT) begin
                    cursor     <= TAIL_SLOT;
                    res_status <= adll_pkg::ST_END;
                    state      <= S_DONE;
                  end else begin
                    cursor     <= head_right;
                    res_status <= adll_pkg::ST_OK;
                    state      <= S_WREAD;
                  end
                end else begin
                  res_status <= adll_pkg::ST_OK;
                  state      <= S_STEP;
                end
              end
              default: begin
                res_status <= adll_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (!n_live) begin
            res_status <= adll_pkg::ST_BAD_HANDLE;
            state      <= S_DONE;
          end else if (kind_q == adll_pkg::KIND_DELETE) begin
            after_q <= p_rdata;
            nxt_q   <= n_right;
            state   <= S_D1;
          end else begin
            after_q <= (kind_q == adll_pkg::KIND_LEFT_INS) ? p_rdata : slot_q;
            nxt_q   <= (kind_q == adll_pkg::KIND_LEFT_INS) ? slot_q : n_right;
            if (full) begin
              res_status <= adll_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_W1;
            end
          end
        end
        S_W1: state <= S_W2;
        S_W2: begin
          if (nxt_q == TAIL_SLOT) begin
            tail_left <= new_slot;
          end
          if (after_q == HEAD_SLOT) begin
            head_right <= new_slot;
          end
          res_handle <= HW'(new_slot - SW'(1));
          next_free  <= next_free + FW'(1);
          state      <= S_DONE;
        end
        S_D1: begin
          if (nxt_q == TAIL_SLOT) begin
            tail_left <= after_q;
          end
          if (after_q == HEAD_SLOT) begin
            head_right <= nxt_q;
          end
          if (cursor == slot_q) begin
            cursor <= after_q;
          end
          state <= S_D2;
        end
        S_D2: state <= S_DONE;
        S_STEP: begin
          if (n_right == TAIL_SLOT) begin
            cursor     <= TAIL_SLOT;
            res_status <= adll_pkg::ST_END;
            state      <= S_DONE;
          end else begin
            cursor <= n_right;
            state  <= S_WREAD;
          end
        end
        S_WREAD: begin
          res_value <= n_value;
          res_last  <= (n_right == TAIL_SLOT);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            assigned_handle <= res_handle;
            read_value      <= res_value;
            is_last         <= res_last;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/array_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list_unit
// Doubly linked list kept in slot memories with head and tail sentinels.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   kind, node_handle, new_value
//   out      out_valid/out_stall status, assigned_handle, read_value, is_last
//
// One item in, one item out. Head or tail insert goes straight to the writes;
// insert by handle or delete first reads the handle, then does two write
// steps on the memories; a walk step reads up to two entries; a rejected
// item is answered at once, or after the read if the handle is dead or full.
// Sentinel links live in registers; memory entries are written before use, so
// reset needs no clearing pass. A stalled result is held
// in the output register while the next item is already being worked on.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [adll_pkg::KIND_W-1:0]        kind,
  input  logic [$clog2(CAPACITY+1)-1:0]      node_handle,
  input  logic signed [adll_pkg::DATA_W-1:0] new_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [adll_pkg::STATUS_W-1:0]      status,
  output logic [$clog2(CAPACITY+1)-1:0]      assigned_handle,
  output logic signed [adll_pkg::DATA_W-1:0] read_value,
  output logic                               is_last
);

  localparam int SLOTS = CAPACITY + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int NW    = SW + adll_pkg::DATA_W + 1;

  logic          p_we;
  logic [SW-1:0] p_waddr;
  logic [SW-1:0] p_wdata;
  logic [SW-1:0] p_raddr;
  logic [SW-1:0] p_rdata;
  logic          n_we;
  logic [NW-1:0] n_wmask;
  logic [SW-1:0] n_waddr;
  logic [NW-1:0] n_wdata;
  logic [SW-1:0] n_raddr;
  logic [NW-1:0] n_rdata;

  // left links
  adll_ram #(
    .DEPTH(SLOTS),
    .WIDTH(SW)
  ) u_left_ram (
    .clk  (clk),
    .we   (p_we),
    .wmask({SW{1'b1}}),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // live bit, right link, value
  adll_ram #(
    .DEPTH(SLOTS),
    .WIDTH(NW)
  ) u_node_ram (
    .clk  (clk),
    .we   (n_we),
    .wmask(n_wmask),
    .waddr(n_waddr),
    .wdata(n_wdata),
    .raddr(n_raddr),
    .rdata(n_rdata)
  );

  adll_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .node_handle    (node_handle),
    .new_value      (new_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .assigned_handle(assigned_handle),
    .read_value     (read_value),
    .is_last        (is_last),
    .p_we           (p_we),
    .p_waddr        (p_waddr),
    .p_wdata        (p_wdata),
    .p_raddr        (p_raddr),
    .p_rdata        (p_rdata),
    .n_we           (n_we),
    .n_wmask        (n_wmask),
    .n_waddr        (n_waddr),
    .n_wdata        (n_wdata),
    .n_raddr        (n_raddr),
    .n_rdata        (n_rdata)
  );

endmodule

// File: sim/array_doubly_linked_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_unit_tb
// Drives list requests (inserts at the ends and next to a handle, deletes,
// cursor walks, unused kinds) through the valid/stall input channel and
// checks every result against a slot-array model of the list kept here.
// A short directed sequence covers the end-of-list, bad-handle and
// delete-under-cursor cases; a random mix follows, then a final walk burst.
// Both channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_unit_tb;

  localparam int CAPACITY     = 1024;
  localparam int HW           = $clog2(CAPACITY + 1);
  localparam int SLOTS        = CAPACITY + 2;
  localparam int HEAD_SLOT    = 0;
  localparam int TAIL_SLOT    = 1;
  localparam int RANDOM_ITEMS = 780;
  localparam int QUIET_TAIL   = 100;
  localparam logic [adll_pkg::KIND_W-1:0] KIND_NOP = 3'd7;

  typedef struct {
    logic [adll_pkg::KIND_W-1:0] k;
    logic [HW-1:0]               h;
    logic [adll_pkg::DATA_W-1:0] v;
  } list_req_t;

  typedef struct {
    adll_pkg::status_t           st;
    logic [HW-1:0]               handle;
    logic [adll_pkg::DATA_W-1:0] data;
    logic                        last;
  } list_res_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [adll_pkg::KIND_W-1:0]         kind;
  logic [HW-1:0]                       node_handle;
  logic signed [adll_pkg::DATA_W-1:0]  new_value;
  logic                                out_valid;
  logic                                out_stall;
  logic [adll_pkg::STATUS_W-1:0]       status;
  logic [HW-1:0]                       assigned_handle;
  logic signed [adll_pkg::DATA_W-1:0]  read_value;
  logic                                is_last;

  // list model
  logic [adll_pkg::DATA_W-1:0] slot_data [SLOTS];
  int                left_of   [SLOTS];
  int                right_of  [SLOTS];
  bit                in_list   [SLOTS];
  int                fresh_slot;
  int                walk_pos;

  // stimulus-side view of which handles are live
  bit                gen_alive [CAPACITY+1];
  int                gen_used;
  int                live_h [$];
  int                dead_h [$];

  list_req_t         list_reqs_q [$];
  list_res_t         list_answers_q [$];
  int                mismatches;
  int                send_gap;
  int                stall_left;
  bit                idle_on = 1'b1;

  array_doubly_linked_list_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .node_handle    (node_handle),
    .new_value      (new_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .assigned_handle(assigned_handle),
    .read_value     (read_value),
    .is_last        (is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_list();
    for (int i = 0; i < SLOTS; i++) begin
      slot_data[i] = '0;
      left_of[i]   = 0;
      right_of[i]  = 0;
      in_list[i]   = 1'b0;
    end
    right_of[HEAD_SLOT] = TAIL_SLOT;
    left_of[TAIL_SLOT]  = HEAD_SLOT;
    fresh_slot = 2;
    walk_pos   = TAIL_SLOT;
  endfunction

  function automatic void read_at_walk(inout list_res_t r);
    if (walk_pos == TAIL_SLOT || walk_pos == HEAD_SLOT) begin
      walk_pos = TAIL_SLOT;
      r.st = adll_pkg::ST_END;
    end else begin
      r.data = slot_data[walk_pos];
      r.last = (right_of[walk_pos] == TAIL_SLOT);
    end
  endfunction

  function automatic list_res_t apply_list_op(logic [adll_pkg::KIND_W-1:0] k,
                                              logic [HW-1:0] h,
                                              logic [adll_pkg::DATA_W-1:0] v);
    list_res_t r;
    int        hs;
    int        s;
    int        after;
    int        nxt;
    bit        ok;
    r.st     = adll_pkg::ST_OK;
    r.handle = '0;
    r.data   = '0;
    r.last   = 1'b0;
    hs = int'(h) + 1;
    ok = (h >= 1) && (int'(h) <= CAPACITY) && (hs < fresh_slot) && in_list[hs];
    case (k)
      adll_pkg::KIND_HEAD_INS, adll_pkg::KIND_TAIL_INS,
      adll_pkg::KIND_LEFT_INS, adll_pkg::KIND_RIGHT_INS: begin
        if ((k == adll_pkg::KIND_LEFT_INS || k == adll_pkg::KIND_RIGHT_INS) && !ok) begin
          r.st = adll_pkg::ST_BAD_HANDLE;
        end else begin
          if (k == adll_pkg::KIND_HEAD_INS) after = HEAD_SLOT;
          else if (k == adll_pkg::KIND_TAIL_INS) after = left_of[TAIL_SLOT];
          else if (k == adll_pkg::KIND_LEFT_INS) after = left_of[hs];
          else after = hs;
          if (fresh_slot >= SLOTS) begin
            r.st = adll_pkg::ST_FULL;
          end else begin
            s   = fresh_slot;
            nxt = right_of[after];
            slot_data[s]  = v;
            left_of[s]    = after;
            right_of[s]   = nxt;
            left_of[nxt]  = s;
            right_of[after] = s;
            in_list[s]    = 1'b1;
            fresh_slot    = s + 1;
            r.handle      = HW'(s - 1);
          end
        end
      end
      adll_pkg::KIND_DELETE: begin
        if (!ok) begin
          r.st = adll_pkg::ST_BAD_HANDLE;
        end else begin
          left_of[right_of[hs]] = left_of[hs];
          right_of[left_of[hs]] = right_of[hs];
          in_list[hs] = 1'b0;
          if (walk_pos == hs) walk_pos = left_of[hs];
        end
      end
      adll_pkg::KIND_WALK_START: begin
        walk_pos = right_of[HEAD_SLOT];
        read_at_walk(r);
      end
      adll_pkg::KIND_WALK_NEXT: begin
        if (walk_pos == TAIL_SLOT) begin
          r.st = adll_pkg::ST_END;
        end else begin
          walk_pos = right_of[walk_pos];
          read_at_walk(r);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_item(logic [adll_pkg::KIND_W-1:0] k, int h,
                                   logic [adll_pkg::DATA_W-1:0] v);
    list_req_t req;
    bit        ok;
    req.k = k;
    req.h = h[HW-1:0];
    req.v = v;
    list_reqs_q.push_back(req);
    ok = (h >= 1) && (h <= gen_used) && gen_alive[h];
    if (k == adll_pkg::KIND_HEAD_INS || k == adll_pkg::KIND_TAIL_INS ||
        ((k == adll_pkg::KIND_LEFT_INS || k == adll_pkg::KIND_RIGHT_INS) && ok)) begin
      if (gen_used < CAPACITY) begin
        gen_used++;
        gen_alive[gen_used] = 1'b1;
        live_h.push_back(gen_used);
      end
    end else if (k == adll_pkg::KIND_DELETE && ok) begin
      gen_alive[h] = 1'b0;
      dead_h.push_back(h);
      foreach (live_h[i]) begin
        if (live_h[i] == h) begin
          live_h.delete(i);
          break;
        end
      end
    end
  endfunction

  function automatic int pick_handle();
    if ($urandom_range(0, 99) < 80 && live_h.size() != 0)
      return live_h[$urandom_range(0, live_h.size() - 1)];
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(CAPACITY + 1, (1 << HW) - 1);
      2: return (dead_h.size() != 0) ? dead_h[$urandom_range(0, dead_h.size() - 1)]
                                     : $urandom_range(0, (1 << HW) - 1);
      3: return (gen_used < CAPACITY) ? $urandom_range(gen_used + 1, CAPACITY) : 0;
      default: return $urandom_range(0, (1 << HW) - 1);
    endcase
  endfunction

  function automatic logic [adll_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int any_live();
    return (live_h.size() != 0) ? live_h[$urandom_range(0, live_h.size() - 1)] : 1;
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) idle_on <= !idle_on;
  end

  // request driver
  always @(posedge clk) begin
    list_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        list_answers_q.push_back(apply_list_op(kind, node_handle, new_value));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (list_reqs_q.size() != 0) begin
          req = list_reqs_q.pop_front();
          kind        <= req.k;
          node_handle <= req.h;
          new_value   <= req.v;
          in_valid    <= 1'b1;
          if (idle_on && list_reqs_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    list_res_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (list_answers_q.size() == 0) begin
          $error("result item with no request outstanding");
          mismatches++;
        end else begin
          want = list_answers_q.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatches++;
          end
          if (assigned_handle !== want.handle) begin
            $error("assigned_handle: expected %0d, got %0d", want.handle, assigned_handle);
            mismatches++;
          end
          if (read_value !== want.data) begin
            $error("read_value: expected %0d, got %0d", $signed(want.data), read_value);
            mismatches++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, is_last);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && list_reqs_q.size() > QUIET_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 16);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    int pick;
    int burst;
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = adll_pkg::KIND_HEAD_INS;
    node_handle = '0;
    new_value   = '0;
    out_stall   = 1'b0;
    mismatches  = 0;
    gen_used    = 0;
    for (int i = 0; i <= CAPACITY; i++) gen_alive[i] = 1'b0;
    clear_list();

    // empty list, bad handles, unused kind
    add_item(adll_pkg::KIND_WALK_START, 0, 0);
    add_item(adll_pkg::KIND_WALK_NEXT, 0, 0);
    add_item(adll_pkg::KIND_DELETE, 1, $urandom);
    add_item(adll_pkg::KIND_LEFT_INS, 0, 32'h1234_5678);
    add_item(adll_pkg::KIND_RIGHT_INS, 2047, 32'hFFFF_FFFF);
    add_item(KIND_NOP, 2047, 32'hFFFF_FFFF);
    // list becomes 3 1 5 4 2 6
    add_item(adll_pkg::KIND_HEAD_INS, 0, 32'h7FFF_FFFF);
    add_item(adll_pkg::KIND_TAIL_INS, 1024, 32'h8000_0000);
    add_item(adll_pkg::KIND_HEAD_INS, 0, 32'h0000_0000);
    add_item(adll_pkg::KIND_LEFT_INS, 2, 32'hFFFF_FFFF);
    add_item(adll_pkg::KIND_RIGHT_INS, 1, 32'h5555_5555);
    add_item(adll_pkg::KIND_RIGHT_INS, 2, 32'hAAAA_AAAA);
    // delete the node under the cursor, then reuse the dead handle
    add_item(adll_pkg::KIND_WALK_START, 0, 0);
    add_item(adll_pkg::KIND_WALK_NEXT, 0, 0);
    add_item(adll_pkg::KIND_DELETE, 1, 0);
    add_item(adll_pkg::KIND_DELETE, 1, 0);
    add_item(adll_pkg::KIND_LEFT_INS, 1, 32'h0BAD_0BAD);
    repeat (5) add_item(adll_pkg::KIND_WALK_NEXT, 0, 0);
    add_item(adll_pkg::KIND_WALK_NEXT, 2047, 32'hFFFF_FFFF);
    add_item(adll_pkg::KIND_DELETE, 1024, 0);
    add_item(adll_pkg::KIND_DELETE, 7, 0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) add_item(adll_pkg::KIND_HEAD_INS, pick_handle(), pick_value());
      else if (pick < 32) add_item(adll_pkg::KIND_TAIL_INS, pick_handle(), pick_value());
      else if (pick < 44) add_item(adll_pkg::KIND_LEFT_INS, pick_handle(), pick_value());
      else if (pick < 56) add_item(adll_pkg::KIND_RIGHT_INS, pick_handle(), pick_value());
      else if (pick < 70) add_item(adll_pkg::KIND_DELETE, pick_handle(), pick_value());
      else if (pick < 78) begin
        burst = $urandom_range(1, 15);
        add_item(adll_pkg::KIND_WALK_START, pick_handle(), pick_value());
        repeat (burst) add_item(adll_pkg::KIND_WALK_NEXT, pick_handle(), pick_value());
        n += burst;
      end else if (pick < 97) add_item(adll_pkg::KIND_WALK_NEXT, pick_handle(), pick_value());
      else begin
        add_item(KIND_NOP, pick_handle(), pick_value());
        continue;
      end
      n++;
    end

    // final edits and walk burst
    add_item(adll_pkg::KIND_LEFT_INS, any_live(), pick_value());
    add_item(adll_pkg::KIND_DELETE, any_live(), 0);
    add_item(adll_pkg::KIND_WALK_START, 0, 0);
    repeat (20) add_item(adll_pkg::KIND_WALK_NEXT, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (list_reqs_q.size() != 0 || in_valid) @(posedge clk);
    while (list_answers_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
